// ===== hw/rtl/mchs_pkg.sv =====
// Shared types and sizing constants for the max cut height search block.
// No dependencies; imported by every module of the block except mchs_ram.
`timescale 1ns / 1ps

package mchs_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int HEIGHT_W  = 32;
  localparam int REQ_W     = 42;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int SRCH_W    = HEIGHT_W + 1;
  localparam int SUM_W     = HEIGHT_W + CNT_W;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic                last;
  } item_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] best_threshold;
    logic                found;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // store the accepted height
    logic start;       // open the search range
    logic probe_init;  // latch the midpoint, clear the sum
    logic probe;       // stream the stored heights
    logic decide;      // narrow the range from the sum
    logic emit;        // load the result register, clear the set
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic low_le_high;
    logic pass_done;
    logic reached;
    logic mid_zero;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/mchs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module mchs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/mchs_ctrl.sv =====
// Controller state machine for the max cut height search.
// Depends on mchs_pkg for the command and status structs.
`timescale 1ns / 1ps

module mchs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_last,
  output logic                item_stall,
  input  mchs_pkg::dp_status_t status,
  output mchs_pkg::ctrl_cmd_t  cmd
);
  import mchs_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_CHECK,
    S_PROBE,
    S_DECIDE,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_LOAD: begin
        if (item_valid) begin
          cmd.load = 1'b1;
          if (item_last) begin
            state_next = S_START;
          end
        end
      end
      S_START: begin
        cmd.start  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.low_le_high) begin
          cmd.probe_init = 1'b1;
          state_next     = S_PROBE;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        if (status.pass_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (!status.reached && status.mid_zero) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  assign item_stall = (state != S_LOAD);

endmodule

// ===== hw/rtl/mchs_dp.sv =====
// Datapath for the max cut height search: height store, range registers,
// excess accumulator, config register and result register.
// Depends on mchs_pkg and mchs_ram.
`timescale 1ns / 1ps

module mchs_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [mchs_pkg::HEIGHT_W-1:0] item_height,
  input  logic                   cfg_valid,
  input  logic [mchs_pkg::REQ_W-1:0] cfg_data,
  input  mchs_pkg::ctrl_cmd_t    cmd,
  output mchs_pkg::dp_status_t   status,
  output logic                   result_valid,
  input  logic                   result_stall,
  output mchs_pkg::result_t      result
);
  import mchs_pkg::*;

  logic [REQ_W-1:0]    required;
  logic [CNT_W-1:0]    count;
  logic [HEIGHT_W-1:0] max_h;
  logic [SRCH_W-1:0]   low;
  logic [SRCH_W-1:0]   high;
  logic [SRCH_W-1:0]   mid;
  logic [SUM_W-1:0]    sum;
  logic [HEIGHT_W-1:0] best;
  logic                found;
  logic [CNT_W-1:0]    rd_idx;
  logic                rd_vld;
  logic [HEIGHT_W-1:0] excess;
  logic                ex_vld;

  logic                store_we;
  logic                rd_en;
  logic [HEIGHT_W-1:0] rd_data;
  logic [SRCH_W-1:0]   span;

  assign store_we = cmd.load && (count < CNT_W'(MAX_ITEMS));
  assign rd_en    = cmd.probe && (rd_idx < count);
  assign span     = high - low;

  mchs_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (item_height),
    .re    (rd_en),
    .raddr (rd_idx[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  always_comb begin
    status.low_le_high = (low <= high);
    status.pass_done   = (rd_idx == count) && !rd_vld && !ex_vld;
    status.reached     = (sum >= SUM_W'(required));
    status.mid_zero    = (mid == '0);
    status.out_free    = !result_valid || !result_stall;
  end

  // Control state and config.
  always_ff @(posedge clk) begin
    if (rst) begin
      required     <= '0;
      count        <= '0;
      max_h        <= '0;
      found        <= 1'b0;
      rd_vld       <= 1'b0;
      ex_vld       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        required <= cfg_data;
      end
      if (store_we) begin
        count <= count + CNT_W'(1);
        if (item_height > max_h) begin
          max_h <= item_height;
        end
      end
      if (cmd.start) begin
        found <= 1'b0;
      end else if (cmd.decide && status.reached) begin
        found <= 1'b1;
      end
      rd_vld <= rd_en;
      ex_vld <= rd_vld;
      if (cmd.emit) begin
        result_valid <= 1'b1;
        count        <= '0;
        max_h        <= '0;
        found        <= 1'b0;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Search payload registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      low  <= '0;
      high <= SRCH_W'(max_h);
      best <= '0;
    end
    if (cmd.probe_init) begin
      mid    <= low + (span >> 1);
      rd_idx <= '0;
    end
    if (rd_en) begin
      rd_idx <= rd_idx + CNT_W'(1);
    end
    if (rd_vld) begin
      excess <= (SRCH_W'(rd_data) > mid) ? (rd_data - mid[HEIGHT_W-1:0]) : '0;
    end
    if (cmd.probe_init) begin
      sum <= '0;
    end else if (ex_vld) begin
      sum <= sum + SUM_W'(excess);
    end
    if (cmd.decide) begin
      if (status.reached) begin
        best <= mid[HEIGHT_W-1:0];
        low  <= mid + SRCH_W'(1);
      end else if (!status.mid_zero) begin
        high <= mid - SRCH_W'(1);
      end
    end
    if (cmd.emit) begin
      result.best_threshold <= found ? best : '0;
      result.found          <= found;
      best                  <= '0;
    end
  end

endmodule

// ===== hw/rtl/max_cut_height_search.sv =====
// Top level of the max cut height search block.
// Depends on mchs_pkg, mchs_ctrl, mchs_dp and mchs_ram.
`timescale 1ns / 1ps

// Heights arrive one request per cycle on the item channel and are written to
// a 1024-entry store while their maximum is tracked; a height that arrives
// with the store full is dropped. The request marked last starts a binary
// search over thresholds 0..max for the greatest threshold whose summed
// excess of stored heights reaches required_amount; the answer, or found = 0
// with threshold 0, leaves as one request on the result channel, and the set
// is cleared for the next one. Each probe of the search is a range check, a
// pass that reads every stored height through the single read port of the
// store and accumulates their excess above the midpoint, and a decision; a
// search takes at most 33 probes. The item channel stalls from the last
// height until the result is handed to the output register; that register lets
// the next set load while a result is still waiting. Write required_amount
// only while the block is idle; the configuration port always takes a write
// at once.
module max_cut_height_search (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  mchs_pkg::item_t            item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output mchs_pkg::result_t          result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mchs_pkg::REQ_W-1:0] cfg_data
);
  import mchs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Take a config write on any cycle.
  assign cfg_ready = 1'b1;

  // Sequence load, range check, probe pass, decision and result handoff.
  mchs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_last  (item.last),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // Hold the store, search range, excess sum and result register.
  mchs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .item_height  (item.height),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== tb/max_cut_height_search_tb.sv =====
// Self-checking testbench for max_cut_height_search: directed table, then random sets.
// Depends on mchs_pkg and the max_cut_height_search RTL; needs no other files.
`timescale 1ns / 1ps

module max_cut_height_search_tb;
  import mchs_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1330;
  localparam int SETTLE       = 8;    // idle cycles after the last answer before a register write
  localparam int TAIL         = 40;   // cycles to watch for stray results at the end

  typedef enum logic {ROW_AMOUNT, ROW_HEIGHT} row_kind_t;

  // One line of the directed plan: either a register write or one height request.
  typedef struct {
    row_kind_t  kind;
    logic [63:0] value;
    logic       last;
    logic       typed;   // answer written into the row instead of predicted
    result_t    want;
  } plan_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic [REQ_W-1:0] cfg_data = '0;

  max_cut_height_search dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: a private copy of the held set, its maximum and the amount.
  // ---------------------------------------------------------------------------
  logic [HEIGHT_W-1:0] held_heights [MAX_ITEMS];
  int unsigned         held_count = 0;
  logic [HEIGHT_W-1:0] held_max = '0;
  logic [REQ_W-1:0]    amount_cfg = '0;

  // Summed excess of the held heights above one threshold.
  function automatic logic [63:0] excess_above(input logic [SRCH_W-1:0] thr);
    logic [63:0] sum;
    sum = '0;
    for (int k = 0; k < held_count; k++) begin
      if ({1'b0, held_heights[k]} > thr)
        sum += 64'({1'b0, held_heights[k]} - thr);
    end
    return sum;
  endfunction

  // Binary search over 0..max for the greatest threshold that still yields the amount.
  function automatic result_t search_cut_height();
    logic [SRCH_W-1:0] lo, hi, mid;
    result_t answer;
    lo = '0;
    hi = {1'b0, held_max};
    answer = '0;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (excess_above(mid) >= {22'b0, amount_cfg}) begin
        answer.best_threshold = mid[HEIGHT_W-1:0];
        answer.found = 1'b1;
        lo = mid + 1;
      end else begin
        if (mid == 0) break;
        hi = mid - 1;
      end
    end
    return answer;
  endfunction

  // Fold one accepted height into the set; returns 1 with the answer when it closes the set.
  function automatic logic absorb_height(input logic [HEIGHT_W-1:0] h, input logic last,
                                         output result_t answer);
    answer = '0;
    // A full store drops the height and leaves the maximum alone.
    if (held_count < MAX_ITEMS) begin
      held_heights[held_count] = h;
      held_count++;
      if (h > held_max) held_max = h;
    end
    if (!last) return 1'b0;
    answer = search_cut_height();
    held_count = 0;
    held_max = '0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Answers still owed by the block, oldest first, and the run's bookkeeping.
  // ---------------------------------------------------------------------------
  result_t pending_cuts [$];
  int unsigned mismatches = 0;
  int unsigned answers_seen = 0;
  int unsigned heights_sent = 0;
  int unsigned sets_closed = 0;
  int unsigned sets_found = 0;
  int unsigned amounts_written = 0;
  int unsigned full_sets = 0;
  int unsigned burst_left = 0;
  int unsigned cycles = 0;
  result_t     owed_cut;

  always @(posedge clk) cycles <= cycles + 1;

  // Give up on a hung block.
  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d answers still owed", cycles, pending_cuts.size());
    $display("Regression FAIL");
    $finish;
  end

  // Receiver: stall in moods that last a random stretch each - free-flowing,
  // coin-flip, or mostly stalled - so results wait out every phase of the search.
  int unsigned stall_mood = 0;
  int unsigned mood_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (mood_left == 0) begin
        stall_mood = $urandom_range(0, 2);
        mood_left = $urandom_range(20, 200);
      end else begin
        mood_left--;
      end
      case (stall_mood)
        0: result_stall <= 1'b0;
        1: result_stall <= 1'($urandom_range(0, 1));
        default: result_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Checker: compare each accepted result against the oldest owed answer.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_cuts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: threshold %h found %b",
                   result.best_threshold, result.found);
      end else begin
        owed_cut = pending_cuts.pop_front();
        answers_seen++;
        if (result.best_threshold !== owed_cut.best_threshold ||
            result.found !== owed_cut.found) begin
          mismatches++;
          if (mismatches <= 10)
            $display("answer %0d: expected threshold %h found %b, got threshold %h found %b",
                     answers_seen, owed_cut.best_threshold, owed_cut.found,
                     result.best_threshold, result.found);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender tasks. Inputs move on falling edges; send_height and drain end after a rising edge.
  // ---------------------------------------------------------------------------

  // Drop valid for a number of cycles.
  task automatic hold_off(input int unsigned gap);
    @(negedge clk);
    item_valid <= 1'b0;
    repeat (gap - 1) @(negedge clk);
  endtask

  // Offer one height request and hold it until accepted; record what the block owes.
  task automatic send_height(input logic [HEIGHT_W-1:0] h, input logic last,
                             input logic typed, input result_t typed_answer);
    result_t answer;
    int unsigned gap;
    // Work in bursts: a fresh burst may open after a gap, or run straight on.
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) hold_off(gap);
    end
    burst_left--;
    @(negedge clk);
    item_valid <= 1'b1;
    item <= '{height: h, last: last};
    do @(posedge clk); while (item_stall);
    heights_sent++;
    if (absorb_height(h, last, answer)) begin
      if (typed) answer = typed_answer;
      pending_cuts.insert(pending_cuts.size(), answer);
      sets_closed++;
      if (answer.found) sets_found++;
    end
  endtask

  // Stop sending, let every owed answer arrive, then let the block settle.
  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_cuts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write required_amount; only called with the block idle.
  task automatic write_amount(input logic [REQ_W-1:0] amount);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= amount;
    do @(posedge clk); while (!cfg_ready);
    amount_cfg = amount;
    amounts_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic plan_row_t mk_row(input row_kind_t kind, input logic [63:0] value,
                                       input logic last, input logic typed,
                                       input logic [HEIGHT_W-1:0] thr, input logic found);
    plan_row_t r;
    r.kind = kind;
    r.value = value;
    r.last = last;
    r.typed = typed;
    r.want.best_threshold = thr;
    r.want.found = found;
    return r;
  endfunction

  // Random height of a given bit width, with the extremes favored.
  function automatic logic [HEIGHT_W-1:0] pick_height(input logic [HEIGHT_W-1:0] mask);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return mask;
      default: return $urandom & mask;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  plan_row_t plan [$];
  localparam logic [REQ_W-1:0] AMOUNT_MAX = '1;
  localparam result_t NO_ANSWER = '0;

  // Append one row to the end of the directed plan.
  function automatic void add_row(input plan_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  initial begin
    int unsigned phase_no;
    int unsigned random_items;
    int unsigned width_pick;
    int unsigned set_size;
    logic [HEIGHT_W-1:0] mask;
    logic [63:0] span;
    logic [REQ_W-1:0] amount;

    // Reset value of the amount is zero, so the first sets must answer with their maximum.
    add_row(mk_row(ROW_HEIGHT, 64'h0, 1'b1, 1'b1, 32'h0, 1'b1));
    add_row(mk_row(ROW_HEIGHT, 64'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1));
    add_row(mk_row(ROW_HEIGHT, 64'd5, 1'b0, 1'b0, 32'h0, 1'b0));
    add_row(mk_row(ROW_HEIGHT, 64'd9, 1'b0, 1'b0, 32'h0, 1'b0));
    add_row(mk_row(ROW_HEIGHT, 64'd3, 1'b1, 1'b1, 32'd9, 1'b1));
    // Largest amount: out of reach even for a full store of all-ones heights.
    add_row(mk_row(ROW_AMOUNT, 64'(AMOUNT_MAX), 1'b0, 1'b0, 32'h0, 1'b0));
    add_row(mk_row(ROW_HEIGHT, 64'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0));
    add_row(mk_row(ROW_HEIGHT, 64'hFFFF_FFFF, 1'b1, 1'b1, 32'h0, 1'b0));
    add_row(mk_row(ROW_HEIGHT, 64'h0, 1'b1, 1'b1, 32'h0, 1'b0));
    // Small amount: a few thresholds pass, then one set that can never reach it.
    add_row(mk_row(ROW_AMOUNT, 64'd10, 1'b0, 1'b0, 32'h0, 1'b0));
    add_row(mk_row(ROW_HEIGHT, 64'd4, 1'b0, 1'b0, 32'h0, 1'b0));
    add_row(mk_row(ROW_HEIGHT, 64'd6, 1'b0, 1'b0, 32'h0, 1'b0));
    add_row(mk_row(ROW_HEIGHT, 64'd8, 1'b1, 1'b0, 32'h0, 1'b0));
    add_row(mk_row(ROW_HEIGHT, 64'h0, 1'b1, 1'b1, 32'h0, 1'b0));
    add_row(mk_row(ROW_AMOUNT, 64'd1, 1'b0, 1'b0, 32'h0, 1'b0));
    add_row(mk_row(ROW_HEIGHT, 64'hAAAA_AAAA, 1'b0, 1'b0, 32'h0, 1'b0));
    add_row(mk_row(ROW_HEIGHT, 64'h5555_5555, 1'b1, 1'b0, 32'h0, 1'b0));
    add_row(mk_row(ROW_HEIGHT, 64'd1, 1'b1, 1'b0, 32'h0, 1'b0));
    // Amount above any single height: the answer needs both heights.
    add_row(mk_row(ROW_AMOUNT, 64'h1_0000_0000, 1'b0, 1'b0, 32'h0, 1'b0));
    add_row(mk_row(ROW_HEIGHT, 64'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0));
    add_row(mk_row(ROW_HEIGHT, 64'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 1'b0));
    // Explicit zero amount after nonzero ones.
    add_row(mk_row(ROW_AMOUNT, 64'h0, 1'b0, 1'b0, 32'h0, 1'b0));
    add_row(mk_row(ROW_HEIGHT, 64'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0));
    add_row(mk_row(ROW_HEIGHT, 64'h7FFF_FFFF, 1'b1, 1'b1, 32'h8000_0000, 1'b1));

    // Hold reset once, then release it.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_AMOUNT) begin
        drain();
        write_amount(plan[i].value[REQ_W-1:0]);
      end else begin
        send_height(plan[i].value[HEIGHT_W-1:0], plan[i].last, plan[i].typed, plan[i].want);
      end
    end

    // Random phases: each picks a width and an amount, then sends several sets or one overfull one.
    phase_no = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      width_pick = $urandom_range(0, 5);
      case (width_pick)
        0: mask = 32'h1;
        1: mask = 32'hF;
        2: mask = 32'hFFF;
        default: mask = 32'hFFFF_FFFF;
      endcase
      span = 64'(mask) * 12;
      case ($urandom_range(0, 5))
        0: amount = '0;
        1: amount = AMOUNT_MAX;
        2: amount = REQ_W'($urandom_range(1, 16));
        default: amount = REQ_W'({$urandom, $urandom} % (span + 1));
      endcase
      drain();

      if (phase_no == 2) begin
        // Overfill the store once: the trailing all-ones heights are dropped,
        // the last one among them, so neither the set nor its maximum may change.
        write_amount(REQ_W'({$urandom, $urandom}) >> 1);
        for (int k = 0; k < MAX_ITEMS; k++)
          send_height($urandom >> 1, 1'b0, 1'b0, NO_ANSWER);
        for (int k = 0; k < 6; k++)
          send_height(32'hFFFF_FFFF, k == 5, 1'b0, NO_ANSWER);
        random_items += MAX_ITEMS + 6;
        full_sets++;
      end else begin
        write_amount(amount);
        repeat ($urandom_range(3, 8)) begin
          // Now and then hold off until the block has answered everything.
          if ($urandom_range(0, 5) == 0) drain();
          set_size = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(1, 12);
          for (int k = 0; k < set_size; k++)
            send_height(pick_height(mask), k == set_size - 1, 1'b0, NO_ANSWER);
          random_items += set_size;
        end
      end
      phase_no++;
    end

    // Wind down: wait for every owed answer, then watch for strays.
    drain();
    repeat (TAIL) @(posedge clk);

    $display("sent %0d heights in %0d sets (%0d found, %0d full-store), %0d amount writes",
             heights_sent, sets_closed, sets_found, full_sets, amounts_written);
    $display("checked %0d answers, %0d mismatches, %0d cycles",
             answers_seen, mismatches, cycles);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
